// ----- design/lkv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key/value cache: request and
// response payloads, request codes, slot update commands and controller states.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int KEY_BITS_DEF  = 64;
	localparam int DATA_BITS_DEF = 64;

	localparam int FIELD_KEY_W  = 64;
	localparam int FIELD_DATA_W = 64;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [FIELD_KEY_W-1:0]  key;
		logic [FIELD_DATA_W-1:0] store_data;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic [FIELD_DATA_W-1:0] lookup_data;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic promote;
		logic fill;
	} slot_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

endpackage

// ----- design/lkv_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_mem
// Key/data store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lkv_mem #(
	parameter int ENTRIES = 16,
	parameter int WIDTH   = 128,
	parameter int IW      = 4
) (
	input  logic             clk,
	input  logic             re,
	input  logic [IW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [ENTRIES];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lkv_slots.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_slots
// Per-slot valid bits and recency ranks with the fill count. Applies clear,
// promote and fill commands and serves one slot to the scan.
// ----------------------------------------------------------------------------
module lkv_slots #(
	parameter int ENTRIES = 16,
	parameter int IW      = 4,
	parameter int CW      = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lkv_pkg::slot_op_t op,
	input  logic [IW-1:0]     tgt,
	input  logic [IW-1:0]     rank,
	input  logic [IW-1:0]     look_idx,
	output logic              look_valid,
	output logic [IW-1:0]     look_age,
	output logic [CW-1:0]     fill_count
);
	import lkv_pkg::*;

	logic          valid_q [ENTRIES];
	logic [IW-1:0] age_q   [ENTRIES];
	logic [CW-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
			fill_q <= '0;
		end else if (op.clear) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
			fill_q <= '0;
		end else if (op.promote) begin
			// age every valid slot more recent than the target, zero the target
			for (int i = 0; i < ENTRIES; i++) begin
				if (IW'(i) == tgt) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && (age_q[i] < rank)) begin
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
			if (op.fill) begin
				valid_q[tgt] <= 1'b1;
				fill_q       <= fill_q + 1'b1;
			end
		end
	end

	assign look_valid = valid_q[look_idx];
	assign look_age   = age_q[look_idx];
	assign fill_count = fill_q;

endmodule

// ----- design/lkv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl
// Request sequencer: for lookup and store, scans the key memory one slot per
// cycle for a match, the lowest free slot and the oldest slot, then commits
// the update and hands the response to the output register.
// ----------------------------------------------------------------------------
module lkv_ctrl #(
	parameter int ENTRIES   = 16,
	parameter int KEY_BITS  = 64,
	parameter int DATA_BITS = 64,
	parameter int IW        = 4,
	parameter int CW        = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  lkv_pkg::req_t               req,
	output logic                        req_stall,
	output logic                        rsp_valid,
	output lkv_pkg::rsp_t               rsp,
	input  logic                        rsp_stall,
	output logic                        mem_re,
	output logic [IW-1:0]               mem_raddr,
	input  logic [KEY_BITS+DATA_BITS-1:0] mem_rdata,
	output logic                        mem_we,
	output logic [IW-1:0]               mem_waddr,
	output logic [KEY_BITS+DATA_BITS-1:0] mem_wdata,
	output lkv_pkg::slot_op_t           slot_op,
	output logic [IW-1:0]               slot_tgt,
	output logic [IW-1:0]               slot_rank,
	output logic [IW-1:0]               look_idx,
	input  logic                        look_valid,
	input  logic [IW-1:0]               look_age,
	input  logic [CW-1:0]               fill_count
);
	import lkv_pkg::*;

	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	state_t state_q, state_d;

	logic [1:0]           type_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [DATA_BITS-1:0] data_q;

	logic          rd_done_q;
	logic [IW-1:0] rd_idx_q;
	logic          chk_vld_s1;
	logic [IW-1:0] chk_idx_s1;

	logic                 found_q;
	logic [IW-1:0]        match_idx_q;
	logic [IW-1:0]        match_age_q;
	logic [DATA_BITS-1:0] match_data_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_idx_q;
	logic [IW-1:0]        old_idx_q;
	logic [IW-1:0]        old_age_q;

	rsp_t res_q;
	rsp_t out_q;
	logic out_valid_q;

	logic accept, rsp_take, scan_issue, scan_end, key_hit, has_room, out_load;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && (state_q == ST_IDLE);
	assign rsp_take   = out_valid_q && !rsp_stall;
	assign scan_issue = (state_q == ST_SCAN) && !rd_done_q;
	assign scan_end   = chk_vld_s1 && (chk_idx_s1 == LAST_IDX);
	assign key_hit    = chk_vld_s1 && look_valid &&
		(mem_rdata[KEY_BITS+DATA_BITS-1:DATA_BITS] == key_q);
	assign has_room   = (fill_count < CW'(ENTRIES));

	assign mem_re    = scan_issue;
	assign mem_raddr = rd_idx_q;
	assign look_idx  = chk_idx_s1;
	assign mem_wdata = {key_q, data_q};
	assign mem_waddr = slot_tgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		slot_op   = '0;
		slot_tgt  = match_idx_q;
		slot_rank = match_age_q;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type) inside
						REQ_LOOKUP, REQ_STORE: begin
							state_d = ST_SCAN;
						end
						REQ_CLEAR: begin
							slot_op.clear = 1'b1;
							state_d       = ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (type_q == REQ_STORE) begin
					slot_op.promote = 1'b1;
					mem_we          = 1'b1;
					if (!found_q) begin
						if (has_room) begin
							slot_tgt     = free_idx_q;
							slot_rank    = IW'(fill_count);
							slot_op.fill = 1'b1;
						end else begin
							// evict the oldest, lowest index on a tie
							slot_tgt  = old_idx_q;
							slot_rank = old_age_q;
						end
					end
				end else if (found_q) begin
					slot_op.promote = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp_take) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_done_q    <= 1'b0;
			chk_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			chk_vld_s1 <= scan_issue;
			if (accept) begin
				rd_done_q    <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (scan_issue && (rd_idx_q == LAST_IDX)) begin
					rd_done_q <= 1'b1;
				end
				if (key_hit) begin
					found_q <= 1'b1;
				end
				if (chk_vld_s1 && !look_valid) begin
					free_found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		if (accept) begin
			type_q   <= req.req_type;
			key_q    <= req.key[KEY_BITS-1:0];
			data_q   <= req.store_data[DATA_BITS-1:0];
			rd_idx_q <= '0;
			res_q    <= '0;
		end else if (scan_issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (key_hit && !found_q) begin
			match_idx_q  <= chk_idx_s1;
			match_age_q  <= look_age;
			match_data_q <= mem_rdata[DATA_BITS-1:0];
		end
		if (chk_vld_s1 && !look_valid && !free_found_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (chk_vld_s1 && ((chk_idx_s1 == '0) || (look_age > old_age_q))) begin
			old_idx_q <= chk_idx_s1;
			old_age_q <= look_age;
		end
		if ((state_q == ST_DECIDE) && (type_q == REQ_LOOKUP) && found_q) begin
			res_q.hit         <= 1'b1;
			res_q.lookup_data <= FIELD_DATA_W'(match_data_q);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- design/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// Keys and data live in a synchronous memory; ranks and valid bits sit in
// per-slot registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_type, key, store_data
//  rsp     | out       | rsp_valid/rsp_stall  | hit, lookup_data
//
//  Lookup and store read the key memory one slot per cycle, then pass a
//  commit state and a state that loads the output register. Clear and the
//  unused code go straight to the state that loads the output register.
//  Reset empties the table at once. A new request is taken while the
//  previous response still waits on rsp_stall; it then holds in its last
//  state until the output register frees.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES   = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS  = lkv_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = lkv_pkg::DATA_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  lkv_pkg::req_t req,
	output logic          req_stall,
	output logic          rsp_valid,
	output lkv_pkg::rsp_t rsp,
	input  logic          rsp_stall
);
	import lkv_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int MW = KEY_BITS + DATA_BITS;

	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr;
	logic [MW-1:0] mem_rdata, mem_wdata;
	slot_op_t      slot_op;
	logic [IW-1:0] slot_tgt, slot_rank, look_idx, look_age;
	logic          look_valid;
	logic [CW-1:0] fill_count;

	lkv_ctrl #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS),
		.DATA_BITS(DATA_BITS),
		.IW       (IW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.slot_op   (slot_op),
		.slot_tgt  (slot_tgt),
		.slot_rank (slot_rank),
		.look_idx  (look_idx),
		.look_valid(look_valid),
		.look_age  (look_age),
		.fill_count(fill_count)
	);

	lkv_mem #(
		.ENTRIES(ENTRIES),
		.WIDTH  (MW),
		.IW     (IW)
	) u_mem (
		.clk  (clk),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata)
	);

	lkv_slots #(
		.ENTRIES(ENTRIES),
		.IW     (IW),
		.CW     (CW)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (slot_op),
		.tgt       (slot_tgt),
		.rank      (slot_rank),
		.look_idx  (look_idx),
		.look_valid(look_valid),
		.look_age  (look_age),
		.fill_count(fill_count)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request channel open right after a transfer");

	a_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> req_stall)
		else $error("key memory written outside a request");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= CW'(ENTRIES))
		else $error("fill count beyond table size");

	a_op_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_op.clear && (slot_op.promote || slot_op.fill)))
		else $error("clear issued together with a slot update");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key/value cache. Requests go in through the
// valid/stall channel with random gaps. Each accepted request runs through a
// local cache model that holds slots, ranks and fill count. The model's
// response is queued, and each response transfer is compared against the
// oldest queued one. Directed corner cases come first, then key-pool traffic,
// fill-and-evict sequences, raw field noise and a final phase with no idling.
// ----------------------------------------------------------------------------
module tb_top;

	import lkv_pkg::*;

	localparam int ENTRIES   = ENTRIES_DEF;
	localparam int KEY_BITS  = KEY_BITS_DEF;
	localparam int DATA_BITS = DATA_BITS_DEF;

	localparam logic [FIELD_KEY_W-1:0]  KEY_MASK  =
		{FIELD_KEY_W{1'b1}} >> (FIELD_KEY_W - KEY_BITS);
	localparam logic [FIELD_DATA_W-1:0] DATA_MASK =
		{FIELD_DATA_W{1'b1}} >> (FIELD_DATA_W - DATA_BITS);

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 1000;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	req_t  req       = '0;
	logic  req_stall;
	logic  rsp_valid;
	rsp_t  rsp;
	logic  rsp_stall = 1'b0;

	// cache model state
	bit                     slot_used [ENTRIES];
	logic [FIELD_KEY_W-1:0] slot_tag  [ENTRIES];
	logic [FIELD_DATA_W-1:0] slot_word [ENTRIES];
	int                     slot_rank [ENTRIES];
	int                     used_count;

	rsp_t pending_rsp[$];

	int  fail_count   = 0;
	int  checked      = 0;
	int  n_lookup     = 0;
	int  n_hit        = 0;
	int  n_store      = 0;
	int  n_evict      = 0;
	int  n_clear      = 0;
	int  n_unused     = 0;
	int  quiet_cycles = 0;
	int  stall_left   = 0;
	bit  stall_calm   = 1'b0;
	bit  send_calm    = 1'b0;
	bit  no_idle      = 1'b0;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [63:0] k, logic [63:0] d);
		req_t r;
		r.req_type   = op;
		r.key        = k;
		r.store_data = d;
		return r;
	endfunction

	function automatic int find_slot(logic [FIELD_KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_tag[i] == k)
				return i;
		return -1;
	endfunction

	// Age everything younger than rank a by one, then put slot s in front.
	function automatic void move_to_front(int s, int a);
		for (int i = 0; i < ENTRIES; i++)
			if (i != s && slot_used[i] && slot_rank[i] < a)
				slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic void empty_table();
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			slot_rank[i] = 0;
		end
		used_count = 0;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t                    o;
		logic [FIELD_KEY_W-1:0]  k;
		logic [FIELD_DATA_W-1:0] d;
		int                      s;
		o = '0;
		k = r.key & KEY_MASK;
		d = r.store_data & DATA_MASK;
		case (r.req_type)
		REQ_LOOKUP: begin
			n_lookup++;
			s = find_slot(k);
			if (s >= 0) begin
				n_hit++;
				o.hit         = 1'b1;
				o.lookup_data = slot_word[s] & DATA_MASK;
				move_to_front(s, slot_rank[s]);
			end
		end
		REQ_STORE: begin
			n_store++;
			s = find_slot(k);
			if (s >= 0) begin
				slot_word[s] = d;
				move_to_front(s, slot_rank[s]);
			end else if (used_count < ENTRIES) begin
				s = 0;
				while (slot_used[s])
					s++;
				slot_used[s] = 1'b1;
				slot_tag[s]  = k;
				slot_word[s] = d;
				move_to_front(s, used_count);
				used_count++;
			end else begin
				// evict the oldest, lowest index on a tie
				n_evict++;
				s = 0;
				for (int i = 1; i < ENTRIES; i++)
					if (slot_rank[i] > slot_rank[s])
						s = i;
				slot_tag[s]  = k;
				slot_word[s] = d;
				move_to_front(s, slot_rank[s]);
			end
		end
		REQ_CLEAR: begin
			n_clear++;
			empty_table();
		end
		default: begin
			n_unused++;
		end
		endcase
		return o;
	endfunction

	// Call at a rising edge; returns at a rising edge.
	task automatic send(input req_t item);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		pending_rsp.insert(pending_rsp.size(), apply_request(item));
		if ($urandom_range(0, 31) == 0)
			send_calm = !send_calm;
		if (!no_idle && !send_calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			req       <= make_req(2'($urandom_range(0, 3)), rand64(), rand64());
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Response side: random stall bursts, off in the final phase.
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!no_idle && !stall_calm && $urandom_range(0, 3) == 0)
			stall_left = $urandom_range(1, 8);
		if ($urandom_range(0, 63) == 0)
			stall_calm = !stall_calm;
		rsp_stall <= (stall_left > 0) && !no_idle;
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response hit=%0b data=%h", $time, rsp.hit,
					rsp.lookup_data);
				fail_count++;
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				checked++;
				if (rsp.hit !== want.hit) begin
					$display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit,
						rsp.hit);
					fail_count++;
				end
				if (rsp.lookup_data !== want.lookup_data) begin
					$display("%0t: lookup_data mismatch: expected %h, actual %h", $time,
						want.lookup_data, rsp.lookup_data);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired, %0d responses still expected", $time,
				pending_rsp.size());
			$display("** lru_key_value_cache: FAILED **");
			$finish;
		end
	end

	task automatic test_directed_ops();
		logic [63:0] ones;
		ones = '1;
		send(make_req(REQ_LOOKUP, 64'd0, ones));                      // miss on empty table
		send(make_req(REQ_STORE, 64'd0, ones));
		send(make_req(REQ_STORE, ones, 64'd0));
		send(make_req(REQ_LOOKUP, 64'd0, 64'd0));
		send(make_req(REQ_LOOKUP, ones, rand64()));
		send(make_req(REQ_LOOKUP, 64'd1, rand64()));                  // one bit away
		send(make_req(REQ_LOOKUP, ones ^ (64'd1 << 63), rand64()));
		send(make_req(REQ_STORE, 64'd0, 64'h5555_5555_5555_5555));    // overwrite
		send(make_req(REQ_LOOKUP, 64'd0, rand64()));
		send(make_req(REQ_UNUSED, 64'd0, ones));                      // no state change
		send(make_req(REQ_LOOKUP, 64'd0, rand64()));
		send(make_req(REQ_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA));
		send(make_req(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0));
		send(make_req(REQ_CLEAR, 64'd0, 64'd0));
		send(make_req(REQ_LOOKUP, 64'd0, rand64()));
		send(make_req(REQ_LOOKUP, ones, rand64()));
		send(make_req(REQ_STORE, 64'd0, 64'h8000_0000_0000_0001));
		send(make_req(REQ_LOOKUP, 64'd0, rand64()));
		send(make_req(REQ_CLEAR, rand64(), rand64()));
		send(make_req(REQ_UNUSED, ones, ones));
		send(make_req(REQ_LOOKUP, 64'd0, rand64()));
	endtask

	// Traffic over a pool of keys, some of them one bit away from another.
	task automatic test_working_set(input int count, input int pool_max);
		logic [63:0] pool[$];
		logic [63:0] k;
		int          pick;
		repeat ($urandom_range(4, pool_max))
			pool.insert(pool.size(), rand64());
		repeat (4)
			pool.insert(pool.size(), pool[0] ^ (64'd1 << $urandom_range(0, 63)));
		repeat (count) begin
			k    = pool[$urandom_range(0, pool.size() - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send(make_req(REQ_LOOKUP, k, rand64()));
			else if (pick < 93)
				send(make_req(REQ_STORE, k, rand64()));
			else if (pick < 96)
				send(make_req(REQ_LOOKUP, rand64(), rand64()));
			else if (pick < 99)
				send(make_req(REQ_UNUSED, k, rand64()));
			else
				send(make_req(REQ_CLEAR, k, rand64()));
		end
	endtask

	// Fill the table, touch some entries, overflow it, then probe every key.
	task automatic test_lru_replacement(input int rounds);
		logic [63:0] keys[$];
		int          n;
		repeat (rounds) begin
			keys.delete();
			send(make_req(REQ_CLEAR, rand64(), rand64()));
			n = ENTRIES + $urandom_range(1, 6);
			repeat (n)
				keys.insert(keys.size(), rand64());
			for (int i = 0; i < ENTRIES; i++)
				send(make_req(REQ_STORE, keys[i], rand64()));
			repeat ($urandom_range(2, 8))
				send(make_req(REQ_LOOKUP, keys[$urandom_range(0, ENTRIES - 1)], rand64()));
			if ($urandom_range(0, 1))
				send(make_req(REQ_STORE, keys[$urandom_range(0, ENTRIES - 1)], rand64()));
			for (int i = ENTRIES; i < n; i++)
				send(make_req(REQ_STORE, keys[i], rand64()));
			keys.shuffle();
			foreach (keys[i])
				send(make_req(REQ_LOOKUP, keys[i], rand64()));
		end
	endtask

	task automatic test_field_noise(input int count);
		repeat (count)
			send(make_req(2'($urandom_range(0, 3)), rand64(), rand64()));
	endtask

	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_working_set(count, 24);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		empty_table();
		@(posedge clk);
		test_directed_ops();
		test_working_set(300, 40);
		test_lru_replacement(7);
		test_working_set(300, 20);
		test_field_noise(150);
		test_back_to_back(250);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		$display("Covered %0d lookups (%0d hits), %0d stores (%0d evictions),",
			n_lookup, n_hit, n_store, n_evict);
		$display("%0d clears, %0d unused codes; compared %0d responses, %0d mismatches.",
			n_clear, n_unused, checked, fail_count);
		if (fail_count == 0)
			$display("** lru_key_value_cache: PASSED **");
		else
			$display("** lru_key_value_cache: FAILED **");
		$finish;
	end

endmodule
